// ----- src/fip_pkg.sv -----
// fip_pkg: shared types and constants for the Feistel index permutation.
// Depends on nothing; every other file imports it.
`default_nettype none

package fip_pkg;

  // Index space and derived widths
  localparam int MAX_INDEX_BITS = 40;
  localparam int INDEX_W        = MAX_INDEX_BITS;
  localparam int COUNT_W        = MAX_INDEX_BITS + 1;
  localparam int HALF_W         = MAX_INDEX_BITS / 2;
  localparam int H_W            = $clog2(HALF_W + 1);
  localparam int SEED_W         = 64;
  localparam int RF_W           = 32;
  localparam int ROUNDS         = 4;
  localparam int RND_W          = $clog2(ROUNDS);

  localparam logic [H_W-1:0]     H_MIN         = H_W'(1);
  localparam logic [H_W-1:0]     H_MAX         = H_W'(HALF_W);
  localparam logic [RND_W-1:0]   RND_LAST      = RND_W'(ROUNDS - 1);
  localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(524288);

  // Round function and key schedule constants
  localparam logic [SEED_W-1:0] DEFAULT_SEED = 64'h243f_6a88_85a3_08d3;
  localparam logic [RF_W-1:0]   RF_MUL1      = 32'h9e37_79b1;
  localparam logic [RF_W-1:0]   RF_MUL2      = 32'h85eb_ca6b;
  localparam logic [RF_W-1:0]   KEY_STEP     = 32'h0000_9e37;
  localparam int                RF_SHIFT1    = 15;
  localparam int                RF_SHIFT2    = 13;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SEED_W;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_COUNT,
    CFG_PERM_SEED
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_SIZE,
    ST_IDLE,
    ST_RND_A,
    ST_RND_B,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic             size_step;
    logic             load;
    logic             rnd_a;
    logic             rnd_b;
    logic [RND_W-1:0] rnd;
    logic             emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic size_done;
    logic in_oor;
    logic walk_done;
    logic out_free;
    logic count_wr;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/fip_if.sv -----
// Valid/ready channel interfaces: index input, result output, config write.
// Depends on fip_pkg.
`default_nettype none

interface fip_idx_if;
  import fip_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index_in;
  modport source (output valid, output index_in, input ready);
  modport sink   (input valid, input index_in, output ready);
endinterface

interface fip_res_if;
  import fip_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] permuted_index;
  logic               out_of_range;
  modport source (output valid, output permuted_index, output out_of_range, input ready);
  modport sink   (input valid, input permuted_index, input out_of_range, output ready);
endinterface

interface fip_cfg_if;
  import fip_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/fip_ctrl.sv -----
// fip_ctrl: sequencer for sizing, Feistel rounds, cycle walking and result hand-off.
// Depends on fip_pkg.
`default_nettype none

module fip_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire fip_pkg::sts_t sts_i,
  output fip_pkg::cmd_t     cmd_o
);
  import fip_pkg::*;

  state_e           state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             accept;

  assign accept = in_valid_i && in_ready_o;

  // State and round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SIZE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    case (state_q)
      ST_SIZE: begin
        if (sts_i.size_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          rnd_d   = '0;
          state_d = sts_i.in_oor ? ST_EMIT : ST_RND_A;
        end
      end
      ST_RND_A: begin
        state_d = ST_RND_B;
      end
      ST_RND_B: begin
        rnd_d = rnd_q + RND_W'(1);
        if (rnd_q == RND_LAST) state_d = ST_CHECK;
        else state_d = ST_RND_A;
      end
      ST_CHECK: begin
        // walk again until the value falls below the count
        state_d = sts_i.walk_done ? ST_EMIT : ST_RND_A;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a new count needs a fresh half-width search
    if (sts_i.count_wr) state_d = ST_SIZE;
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.rnd  = rnd_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_SIZE:  cmd_o.size_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = !sts_i.count_wr;
        cmd_o.load = accept;
      end
      ST_RND_A: cmd_o.rnd_a = 1'b1;
      ST_RND_B: cmd_o.rnd_b = 1'b1;
      ST_CHECK: cmd_o.rnd_a = 1'b0;
      ST_EMIT:  cmd_o.emit = sts_i.out_free;
      default:  cmd_o.emit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/fip_dpath.sv -----
// fip_dpath: config registers, half-width search, shared round unit, result register.
// Depends on fip_pkg and the channel interfaces in fip_if.sv.
`default_nettype none

module fip_dpath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  fip_idx_if.sink            idx_i,
  fip_res_if.source          res_o,
  fip_cfg_if.sink            cfg_i,
  input  wire fip_pkg::cmd_t cmd_i,
  output fip_pkg::sts_t      sts_o
);
  import fip_pkg::*;

  logic [COUNT_W-1:0] count_q;
  logic [SEED_W-1:0]  seed_q;
  logic [H_W-1:0]     h_q;
  logic [HALF_W-1:0]  lo_q, hi_q, lo_d, hi_d;
  logic [RF_W-1:0]    p1_q, p1_d;
  logic               oor_q;
  logic               out_valid_q;
  logic [INDEX_W-1:0] out_index_q;
  logic               out_oor_q;

  logic               cfg_wr;
  logic [HALF_W-1:0]  mask;
  logic [COUNT_W-1:0] pow;
  logic [INDEX_W-1:0] idx_hi;
  logic [INDEX_W-1:0] v;
  logic [RF_W-1:0]    seed32;
  logic [RF_W-1:0]    key;
  logic [RF_W-1:0]    y, p2, z;
  logic [HALF_W-1:0]  f;

  assign cfg_wr       = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      seed_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        CFG_ELEMENT_COUNT: count_q <= cfg_i.data[COUNT_W-1:0];
        CFG_PERM_SEED:     seed_q  <= cfg_i.data;
        default:           seed_q  <= seed_q;
      endcase
    end
  end

  // Half width search: smallest h with 2^(2h) >= count, capped at HALF_W
  assign pow = COUNT_W'(1) << {h_q, 1'b0};
  assign sts_o.size_done = (h_q == H_MAX) || (pow >= count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= H_MIN;
    end else if (cfg_wr && cfg_i.index == CFG_ELEMENT_COUNT) begin
      h_q <= H_MIN;
    end else if (cmd_i.size_step && !sts_o.size_done) begin
      h_q <= h_q + H_W'(1);
    end
  end

  assign mask = HALF_W'((HALF_W + 1)'(1) << h_q) - HALF_W'(1);

  // Round key: low word of the seed (or of DEFAULT_SEED when the seed is zero) plus a per-round step
  assign seed32 = (seed_q == '0) ? DEFAULT_SEED[RF_W-1:0] : seed_q[RF_W-1:0];
  assign key    = seed32 + KEY_STEP * RF_W'(cmd_i.rnd);

  // Round unit, first half: xor key and first multiply
  assign p1_d = (RF_W'(lo_q) ^ key) * RF_MUL1;

  // Round unit, second half: xorshift, second multiply, xorshift, swap halves
  assign y  = p1_q ^ (p1_q >> RF_SHIFT1);
  assign p2 = y * RF_MUL2;
  assign z  = p2 ^ (p2 >> RF_SHIFT2);
  assign f  = z[HALF_W-1:0] & mask;

  // Split the incoming index into halves
  assign idx_hi = idx_i.index_in >> h_q;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.load) begin
      lo_d = idx_i.index_in[HALF_W-1:0] & mask;
      hi_d = idx_hi[HALF_W-1:0] & mask;
    end else if (cmd_i.rnd_b) begin
      lo_d = hi_q ^ f;
      hi_d = lo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.rnd_a) p1_q <= p1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oor_q <= 1'b0;
    end else if (cmd_i.load) begin
      oor_q <= sts_o.in_oor;
    end
  end

  // Joined value for the cycle-walk compare
  assign v = (INDEX_W'(hi_q) << h_q) | INDEX_W'(lo_q);

  // Result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q <= oor_q ? '0 : v;
      out_oor_q   <= oor_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.permuted_index = out_index_q;
  assign res_o.out_of_range   = out_oor_q;

  // Status
  assign sts_o.in_oor    = {1'b0, idx_i.index_in} >= count_q;
  assign sts_o.walk_done = {1'b0, v} < count_q;
  assign sts_o.out_free  = !out_valid_q || res_o.ready;
  assign sts_o.count_wr  = cfg_wr && cfg_i.index == CFG_ELEMENT_COUNT;

endmodule

`default_nettype wire

// ----- src/feistel_index_permutation.sv -----
// Seeded index permutation: four-round Feistel network over an even width with cycle walking.
// An out-of-range index goes straight to the result register; any other index runs Feistel
// passes of 4 rounds (RND_A then RND_B on one shared round unit), then a range check.
// One index at a time; passes repeat until the value falls below element_count.
// After reset and after each element_count write a half-width search runs with the index
// channel not ready. Reset gives element_count 524288, seed 0.
`default_nettype none

module feistel_index_permutation (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fip_idx_if.sink   idx_i,
  fip_res_if.source res_o,
  fip_cfg_if.sink   cfg_i
);
  import fip_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign idx_i.ready = in_ready;

  // Sequencer
  fip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (idx_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  fip_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (idx_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire
